// ===== rtl/tvd_superbee_advection_stencil_macros.svh =====
// Assertion helpers; clk and rst_n must be in scope at the point of use.
`ifndef TVD_SUPERBEE_ADVECTION_STENCIL_MACROS_SVH
`define TVD_SUPERBEE_ADVECTION_STENCIL_MACROS_SVH

// Same-cycle implication.
`define TVD_SB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TVD_SB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tvd_sb_pkg.sv =====
`default_nettype none
package tvd_sb_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int OUT_WIDTH     = 48;
  localparam int SPACING_WIDTH = 31;
  // part magnitude clamp is 2^PART_LIM_BITS
  localparam int PART_LIM_BITS = 50;

  localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 31'd65536;

  typedef enum logic [0:0] {
    REG_GRID_SPACING_X = 1'b0,
    REG_GRID_SPACING_Z = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/tvd_sb_mul.sv =====
`default_nettype none
// Shared signed multiplier, registered product.
module tvd_sb_mul #(
  parameter int W = 34
) (
  input  wire logic                  clk,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  output logic signed [2*W-1:0]      p
);

  logic signed [2*W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/tvd_superbee_advection_stencil.sv =====
`default_nettype none
// TVD advection stencil with superbee limiter. A grid cell arrives as two
// transfers: the x-axis item first (stored, no result) and then the z-axis
// item, which produces one result: the saturated sum of both axis parts in
// signed Q32.16, with a flag when either the stored x part or the sum was
// clipped. A z item with no x item before it adds zero. Every item runs
// through one sequencer around a single registered multiplier and two
// restoring shift/subtract dividers, and in_ready is low while an item is
// in progress. Per item: each of the four limiters takes two multiplies
// and a check plus FRAC_BITS+1 division steps unless the ratio is zero,
// negative or at least 2; then the eight coefficient products, the six
// stencil partial products and the division by the spacing, plus accept
// and finish steps; the spacing division dominates. The user must write
// the spacing registers over the cfg_ channel only while idle; the block
// does not enforce it. A spacing of zero acts as one LSB.
module tvd_superbee_advection_stencil #(
  parameter int DATA_WIDTH = tvd_sb_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = tvd_sb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_axis,
  input  wire logic signed [DATA_WIDTH-1:0]        in_v_face_plus,
  input  wire logic signed [DATA_WIDTH-1:0]        in_v_face_minus,
  input  wire logic signed [DATA_WIDTH-1:0]        in_v_face_plus_far,
  input  wire logic signed [DATA_WIDTH-1:0]        in_v_face_minus_far,
  input  wire logic signed [DATA_WIDTH-1:0]        in_q_center,
  input  wire logic signed [DATA_WIDTH-1:0]        in_q_plus,
  input  wire logic signed [DATA_WIDTH-1:0]        in_q_plus_far,
  input  wire logic signed [DATA_WIDTH-1:0]        in_q_minus,
  input  wire logic signed [DATA_WIDTH-1:0]        in_q_minus_far,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tvd_sb_pkg::OUT_WIDTH-1:0]  out_advection_term,
  output logic                                     out_saturated,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [tvd_sb_pkg::SPACING_WIDTH-1:0] cfg_data
);

`include "tvd_superbee_advection_stencil_macros.svh"

  localparam int DW    = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int LW    = F + 2;                          // limiter, 0..2 in Q.F
  localparam int PW    = 2 * DW;                         // ratio products
  localparam int MW    = (DW + 2 > F + 3) ? DW + 2 : F + 3; // multiplier operand
  localparam int CW    = DW + F + 4;                     // doubled coefficients
  localparam int SPLIT = MW - 1;                         // low coefficient slice
  localparam int SW    = 2 * DW + F + 5;                 // stencil sum
  localparam int DVW   = tvd_sb_pkg::SPACING_WIDTH + F + 1;
  localparam int PLB   = tvd_sb_pkg::PART_LIM_BITS;
  localparam int QW    = (SW > PLB + 1) ? SW : PLB + 1;
  localparam int PTW   = PLB + 2;                        // signed axis part
  localparam int TW    = PTW + 1;                        // x part + z part
  localparam int OW    = tvd_sb_pkg::OUT_WIDTH;
  localparam int CNTW  = $clog2(SW + 1);

  localparam logic [LW-1:0]  TWO_ONE   = LW'(1) << (F + 1);
  localparam logic [LW-1:0]  ONE_L     = LW'(1) << F;
  localparam logic [F:0]     RQ_HALF   = (F + 1)'(1) << (F - 1);
  localparam logic [F:0]     RQ_ONE    = (F + 1)'(1) << F;
  localparam logic [QW-1:0]  PART_LIM_Q = QW'(1) << PLB;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LMUL = 8'b0000_0010,
    S_LCHK = 8'b0000_0100,
    S_LDIV = 8'b0000_1000,
    S_COEF = 8'b0001_0000,
    S_STEN = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [1:0]              lim_idx_r, lim_idx_nxt;

  logic                    axis_r;
  logic signed [DW-1:0]    v_r [4];   // plus, minus, plus_far, minus_far
  logic signed [DW-1:0]    q_r [5];   // center, plus, plus_far, minus, minus_far

  logic [PW-1:0]           un_r, un_nxt;
  logic [PW-1:0]           ud_r, ud_nxt;
  logic [PW-1:0]           lim_rem_r, lim_rem_nxt;
  logic [F:0]              rq_r, rq_nxt;
  logic [LW-1:0]           lim_r [4];
  logic [LW-1:0]           lim_wdata;
  logic                    lim_we;

  logic signed [CW-1:0]    ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt;
  logic signed [SW-1:0]    sum_r, sum_nxt;
  logic                    neg_r, neg_nxt;
  logic [SW-1:0]           num_r, num_nxt;
  logic [DVW-1:0]          div_rem_r, div_rem_nxt;

  logic signed [OW-1:0]    xsum_r, xsum_nxt;
  logic                    xclip_r, xclip_nxt;
  logic [tvd_sb_pkg::SPACING_WIDTH-1:0] gsx_r, gsz_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]    out_term_r, out_term_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic in_fire, cfg_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_valid          = out_valid_r;
  assign out_advection_term = out_term_r;
  assign out_saturated      = out_sat_r;

  // ---------------------------------------------------------------------
  // Upwind splits of the face velocities
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] vpp, vpm, vmp, vmm, vffm, vffp;

  assign vpp  = v_r[0][DW-1] ? '0 : v_r[0];
  assign vpm  = v_r[0][DW-1] ? v_r[0] : '0;
  assign vmp  = v_r[1][DW-1] ? '0 : v_r[1];
  assign vmm  = v_r[1][DW-1] ? v_r[1] : '0;
  assign vffm = v_r[2][DW-1] ? v_r[2] : '0;
  assign vffp = v_r[3][DW-1] ? '0 : v_r[3];

  // ---------------------------------------------------------------------
  // Limiter operands for the limiter in progress
  // r = (na-nb)/(da-db) * ve/vf
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] na, nb, da, db, ve, vf;
  logic signed [DW:0]   nd, dd;
  logic [DW:0]          nd_mag, dd_mag;
  logic [DW-1:0]        ve_mag, vf_mag;
  logic                 lim_zero;

  always_comb begin
    case (lim_idx_r)
      2'd0: begin  // plus face, positive flow
        na = q_r[0]; nb = q_r[3]; da = q_r[1]; db = q_r[0]; ve = vmp;  vf = vpp;
      end
      2'd1: begin  // plus face, negative flow
        na = q_r[2]; nb = q_r[1]; da = q_r[1]; db = q_r[0]; ve = vffm; vf = vpm;
      end
      2'd2: begin  // minus face, positive flow
        na = q_r[3]; nb = q_r[4]; da = q_r[0]; db = q_r[3]; ve = vffp; vf = vmp;
      end
      default: begin  // minus face, negative flow
        na = q_r[1]; nb = q_r[0]; da = q_r[0]; db = q_r[3]; ve = vpm;  vf = vmm;
      end
    endcase
  end

  assign nd     = {na[DW-1], na} - {nb[DW-1], nb};
  assign dd     = {da[DW-1], da} - {db[DW-1], db};
  assign nd_mag = nd[DW] ? (~nd + 1'b1) : nd;
  assign dd_mag = dd[DW] ? (~dd + 1'b1) : dd;
  assign ve_mag = ve[DW-1] ? (~ve + 1'b1) : ve;
  assign vf_mag = vf[DW-1] ? (~vf + 1'b1) : vf;
  // zero terms or a negative ratio give limiter 0
  assign lim_zero = (nd == '0) || (ve == '0) || (dd == '0) || (vf == '0) ||
                    (nd[DW] ^ ve[DW-1] ^ dd[DW] ^ vf[DW-1]);

  // ---------------------------------------------------------------------
  // Coefficient product selection: velocity times L or (2 - L)
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] coef_vel;
  logic [LW-1:0]        coef_lraw, coef_l;
  logic                 coef_cmp;
  logic [2:0]           cap_k;

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin coef_vel = vmp; coef_lraw = lim_r[2]; coef_cmp = 1'b1; end
      3'd1:    begin coef_vel = vmm; coef_lraw = lim_r[3]; coef_cmp = 1'b0; end
      3'd2:    begin coef_vel = vpp; coef_lraw = lim_r[0]; coef_cmp = 1'b1; end
      3'd3:    begin coef_vel = vpm; coef_lraw = lim_r[1]; coef_cmp = 1'b0; end
      3'd4:    begin coef_vel = vmm; coef_lraw = lim_r[3]; coef_cmp = 1'b1; end
      3'd5:    begin coef_vel = vmp; coef_lraw = lim_r[2]; coef_cmp = 1'b0; end
      3'd6:    begin coef_vel = vpm; coef_lraw = lim_r[1]; coef_cmp = 1'b1; end
      default: begin coef_vel = vpp; coef_lraw = lim_r[0]; coef_cmp = 1'b0; end
    endcase
  end

  assign coef_l = coef_cmp ? (TWO_ONE - coef_lraw) : coef_lraw;
  assign cap_k  = 3'(cnt_r - 1'b1);

  // ---------------------------------------------------------------------
  // Stencil product selection: coefficient slice times quantity
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] sten_coef;
  logic signed [DW-1:0] sten_q;
  logic signed [MW-1:0] sten_slice;

  always_comb begin
    case (cnt_r[2:1])
      2'd0:    begin sten_coef = ca_r; sten_q = q_r[3]; end
      2'd1:    begin sten_coef = cb_r; sten_q = q_r[0]; end
      default: begin sten_coef = cc_r; sten_q = q_r[1]; end
    endcase
  end

  assign sten_slice = cnt_r[0] ? MW'($signed(sten_coef[CW-1:SPLIT]))
                               : $signed(MW'(sten_coef[SPLIT-1:0]));

  // ---------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LMUL: begin
        if (cnt_r == '0) begin
          mul_a = $signed(MW'(nd_mag));
          mul_b = $signed(MW'(ve_mag));
        end else begin
          mul_a = $signed(MW'(dd_mag));
          mul_b = $signed(MW'(vf_mag));
        end
      end
      S_COEF: begin
        mul_a = MW'(coef_vel);
        mul_b = $signed(MW'(coef_l));
      end
      S_STEN: begin
        mul_a = sten_slice;
        mul_b = MW'(sten_q);
      end
      S_IDLE, S_LCHK, S_LDIV, S_DIV, S_FIN: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tvd_sb_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // ---------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------
  // limiter ratio division step
  logic [PW:0] trial_l;
  logic        ge_l;
  assign trial_l = (cnt_r == '0) ? {1'b0, lim_rem_r} : {lim_rem_r, 1'b0};
  assign ge_l    = trial_l >= {1'b0, ud_r};

  // spacing division step
  logic [tvd_sb_pkg::SPACING_WIDTH-1:0] spacing_sel, spacing_nz;
  logic [DVW-1:0] divisor;
  logic [DVW:0]   trial_d;
  logic           ge_d;
  assign spacing_sel = axis_r ? gsz_r : gsx_r;
  assign spacing_nz  = (spacing_sel == '0) ? tvd_sb_pkg::SPACING_WIDTH'(1) : spacing_sel;
  assign divisor     = {spacing_nz, (F + 1)'(0)};
  assign trial_d     = {div_rem_r, num_r[SW-1]};
  assign ge_d        = trial_d >= {1'b0, divisor};

  // stencil term capture
  logic signed [SW-1:0] sten_term;
  assign sten_term = cnt_r[0] ? SW'(mul_p) : (SW'(mul_p) <<< SPLIT);

  // axis part, clamped and signed
  logic [QW-1:0]          qz;
  logic [PLB:0]           part_mag;
  logic signed [PTW-1:0]  part_s;
  logic                   part_fits;
  logic signed [OW-1:0]   part_sat;
  logic signed [TW-1:0]   total;
  logic                   total_fits;
  logic signed [OW-1:0]   total_sat;

  assign qz        = QW'(num_r);
  assign part_mag  = (PLB + 1)'((qz > PART_LIM_Q) ? PART_LIM_Q : qz);
  assign part_s    = neg_r ? -$signed({1'b0, part_mag}) : $signed({1'b0, part_mag});
  assign part_fits = (&part_s[PTW-1:OW-1]) || (~|part_s[PTW-1:OW-1]);
  assign part_sat  = part_fits ? part_s[OW-1:0]
                               : {part_s[PTW-1], {(OW - 1){~part_s[PTW-1]}}};
  assign total      = TW'(xsum_r) + TW'(part_s);
  assign total_fits = (&total[TW-1:OW-1]) || (~|total[TW-1:OW-1]);
  assign total_sat  = total_fits ? total[OW-1:0]
                                 : {total[TW-1], {(OW - 1){~total[TW-1]}}};

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lim_idx_nxt   = lim_idx_r;
    un_nxt        = un_r;
    ud_nxt        = ud_r;
    lim_rem_nxt   = lim_rem_r;
    rq_nxt        = rq_r;
    lim_we        = 1'b0;
    lim_wdata     = '0;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    cc_nxt        = cc_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    num_nxt       = num_r;
    div_rem_nxt   = div_rem_r;
    xsum_nxt      = xsum_r;
    xclip_nxt     = xclip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_term_nxt  = out_term_r;
    out_sat_nxt   = out_sat_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt   = S_LMUL;
          cnt_nxt     = '0;
          lim_idx_nxt = '0;
        end
      end

      // two magnitude products: numerator and denominator of the ratio
      S_LMUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(1)) begin
          un_nxt = mul_p[PW-1:0];
        end
        if (cnt_r == CNTW'(2)) begin
          ud_nxt    = mul_p[PW-1:0];
          state_nxt = S_LCHK;
        end
      end

      S_LCHK: begin
        cnt_nxt = '0;
        if (lim_zero || ({1'b0, un_r} >= {ud_r, 1'b0})) begin
          lim_we    = 1'b1;
          lim_wdata = lim_zero ? '0 : TWO_ONE;
          if (lim_idx_r == 2'd3) begin
            state_nxt = S_COEF;
            ca_nxt    = '0;
            cb_nxt    = '0;
            cc_nxt    = '0;
          end else begin
            lim_idx_nxt = lim_idx_r + 1'b1;
            state_nxt   = S_LMUL;
          end
        end else begin
          lim_rem_nxt = un_r;
          state_nxt   = S_LDIV;
        end
      end

      // restoring division, F+1 quotient bits, then superbee
      S_LDIV: begin
        lim_rem_nxt = PW'(ge_l ? (trial_l - {1'b0, ud_r}) : trial_l);
        rq_nxt      = {rq_r[F-1:0], ge_l};
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNTW'(F)) begin
          lim_we = 1'b1;
          if (rq_nxt < RQ_HALF) begin
            lim_wdata = {rq_nxt, 1'b0};
          end else if (rq_nxt < RQ_ONE) begin
            lim_wdata = ONE_L;
          end else begin
            lim_wdata = LW'(rq_nxt);
          end
          cnt_nxt = '0;
          if (lim_idx_r == 2'd3) begin
            state_nxt = S_COEF;
            ca_nxt    = '0;
            cb_nxt    = '0;
            cc_nxt    = '0;
          end else begin
            lim_idx_nxt = lim_idx_r + 1'b1;
            state_nxt   = S_LMUL;
          end
        end
      end

      // issue product cnt, accumulate product cnt-1
      S_COEF: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          case (cap_k) inside
            3'd0, 3'd1: ca_nxt = ca_r - mul_p[CW-1:0];
            3'd2, 3'd3: cb_nxt = cb_r + mul_p[CW-1:0];
            3'd4, 3'd5: cb_nxt = cb_r - mul_p[CW-1:0];
            default:    cc_nxt = cc_r + mul_p[CW-1:0];
          endcase
        end
        if (cnt_r == CNTW'(8)) begin
          cnt_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_STEN;
        end
      end

      S_STEN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          sum_nxt = sum_r + sten_term;
        end
        if (cnt_r == CNTW'(6)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end

      // first cycle takes the magnitude, then one quotient bit a cycle
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          neg_nxt     = sum_r[SW-1];
          num_nxt     = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
          div_rem_nxt = '0;
        end else begin
          div_rem_nxt = DVW'(ge_d ? (trial_d - {1'b0, divisor}) : trial_d);
          num_nxt     = {num_r[SW-2:0], ge_d};
          if (cnt_r == CNTW'(SW)) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!axis_r) begin
          xsum_nxt  = part_sat;
          xclip_nxt = !part_fits;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_term_nxt  = total_sat;
          out_sat_nxt   = xclip_r || !total_fits;
          xsum_nxt      = '0;
          xclip_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lim_idx_r   <= '0;
      xsum_r      <= '0;
      xclip_r     <= 1'b0;
      out_valid_r <= 1'b0;
      gsx_r       <= tvd_sb_pkg::SPACING_RESET;
      gsz_r       <= tvd_sb_pkg::SPACING_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lim_idx_r   <= lim_idx_nxt;
      xsum_r      <= xsum_nxt;
      xclip_r     <= xclip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          tvd_sb_pkg::REG_GRID_SPACING_X: gsx_r <= cfg_data;
          tvd_sb_pkg::REG_GRID_SPACING_Z: gsz_r <= cfg_data;
        endcase
      end
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      axis_r <= in_axis;
      v_r[0] <= in_v_face_plus;
      v_r[1] <= in_v_face_minus;
      v_r[2] <= in_v_face_plus_far;
      v_r[3] <= in_v_face_minus_far;
      q_r[0] <= in_q_center;
      q_r[1] <= in_q_plus;
      q_r[2] <= in_q_plus_far;
      q_r[3] <= in_q_minus;
      q_r[4] <= in_q_minus_far;
    end
    if (lim_we) begin
      lim_r[lim_idx_r] <= lim_wdata;
    end
    un_r       <= un_nxt;
    ud_r       <= ud_nxt;
    lim_rem_r  <= lim_rem_nxt;
    rq_r       <= rq_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    cc_r       <= cc_nxt;
    sum_r      <= sum_nxt;
    neg_r      <= neg_nxt;
    num_r      <= num_nxt;
    div_rem_r  <= div_rem_nxt;
    out_term_r <= out_term_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TVD_SB_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "block still ready the cycle after a transfer")
  `TVD_SB_ASSERT_NXT(a_x_item_no_result, (state_r == S_FIN) && !axis_r,
    !$rose(out_valid), "x item produced a result")
  `TVD_SB_ASSERT_IMP(a_lim_rem_bound, (state_r == S_LDIV) && (cnt_r != '0),
    lim_rem_r < ud_r, "limiter division remainder out of range")
  `TVD_SB_ASSERT_IMP(a_div_rem_bound, (state_r == S_DIV) && (cnt_r != '0),
    div_rem_r < divisor, "spacing division remainder out of range")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam longint ONE_Q   = 64'sd65536;
  localparam longint TWO_Q   = 64'sd131072;
  localparam longint OUT_HI  = 64'sd140737488355327;
  localparam longint OUT_LO  = -64'sd140737488355328;
  localparam longint PART_CAP = 64'sd1 << tvd_sb_pkg::PART_LIM_BITS;

  typedef struct {
    logic        ax;
    logic [31:0] v[4]; // plus, minus, plus_far, minus_far
    logic [31:0] q[5]; // center, plus, plus_far, minus, minus_far
  } stencil_item_t;

  typedef struct {
    logic [tvd_sb_pkg::OUT_WIDTH-1:0] term;
    logic                             sat;
  } advection_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_axis = 1'b0;
  logic [31:0] in_v_face_plus = '0, in_v_face_minus = '0;
  logic [31:0] in_v_face_plus_far = '0, in_v_face_minus_far = '0;
  logic [31:0] in_q_center = '0, in_q_plus = '0, in_q_plus_far = '0;
  logic [31:0] in_q_minus = '0, in_q_minus_far = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [tvd_sb_pkg::OUT_WIDTH-1:0] out_advection_term;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [tvd_sb_pkg::SPACING_WIDTH-1:0] cfg_data = '0;

  tvd_superbee_advection_stencil i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_axis(in_axis),
    .in_v_face_plus(in_v_face_plus), .in_v_face_minus(in_v_face_minus),
    .in_v_face_plus_far(in_v_face_plus_far),
    .in_v_face_minus_far(in_v_face_minus_far),
    .in_q_center(in_q_center), .in_q_plus(in_q_plus),
    .in_q_plus_far(in_q_plus_far), .in_q_minus(in_q_minus),
    .in_q_minus_far(in_q_minus_far),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_advection_term(out_advection_term), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stencil_item_t  pending_items[$];
  advection_res_t term_queue[$];

  // predictor state
  logic [tvd_sb_pkg::SPACING_WIDTH-1:0] dx_model = tvd_sb_pkg::SPACING_RESET;
  logic [tvd_sb_pkg::SPACING_WIDTH-1:0] dz_model = tvd_sb_pkg::SPACING_RESET;
  longint x_part_model = 0;
  logic   x_clip_model = 1'b0;

  int  mismatches = 0;
  int  items_taken = 0;
  logic in_fired = 1'b0;
  logic cfg_fired = 1'b0;
  logic hold_rx = 1'b0;

  function automatic longint unsigned mag64(longint x);
    return (x < 0) ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  // superbee on r = (na-nb)/(da-db) * ve/vf, result Q.16 in 0..2
  function automatic longint superbee(longint na, longint nb, longint da,
                                      longint db, longint ve, longint vf);
    longint nd, dd;
    logic [63:0] un, ud, rem, rq;
    nd = na - nb;
    dd = da - db;
    if (nd == 0 || ve == 0 || dd == 0 || vf == 0) return 0;
    if (((nd < 0) != (ve < 0)) != ((dd < 0) != (vf < 0))) return 0;
    un = mag64(nd) * mag64(ve);
    ud = mag64(dd) * mag64(vf);
    if (un >= 64'(ud + ud)) return TWO_Q;
    rem = un;
    rq = 0;
    if (rem >= ud) begin
      rem = rem - ud;
      rq = 1;
    end
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      rq = rq << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        rq[0] = 1'b1;
      end
    end
    if (rq < 64'(ONE_Q / 2)) return longint'(rq * 2);
    if (rq < 64'(ONE_Q)) return ONE_Q;
    return longint'(rq);
  endfunction

  // flux divergence of one axis, Q.16, magnitude capped at 2^50
  function automatic longint axis_flux(stencil_item_t it,
                                       logic [tvd_sb_pkg::SPACING_WIDTH-1:0] sp);
    longint v[4], q[5];
    longint pp, pm, mp, mm, ffm, ffp, lpp, lpm, lmp, lmm, ca, cb, cc;
    logic signed [127:0] acc, a, b;
    logic [127:0] umag, dvs, quo;
    logic neg;
    for (int i = 0; i < 4; i++) v[i] = longint'(signed'(it.v[i]));
    for (int i = 0; i < 5; i++) q[i] = longint'(signed'(it.q[i]));
    pp = v[0] > 0 ? v[0] : 0;  pm = v[0] < 0 ? v[0] : 0;
    mp = v[1] > 0 ? v[1] : 0;  mm = v[1] < 0 ? v[1] : 0;
    ffm = v[2] < 0 ? v[2] : 0; ffp = v[3] > 0 ? v[3] : 0;
    lpp = superbee(q[0], q[3], q[1], q[0], mp, pp);
    lpm = superbee(q[2], q[1], q[1], q[0], ffm, pm);
    lmp = superbee(q[3], q[4], q[0], q[3], ffp, mp);
    lmm = superbee(q[1], q[0], q[0], q[3], pm, mm);
    ca = -mp * (TWO_Q - lmp) - mm * lmm;
    cb = pp * (TWO_Q - lpp) + pm * lpm - mm * (TWO_Q - lmm) - mp * lmp;
    cc = pm * (TWO_Q - lpm) + pp * lpp;
    a = ca; b = q[3]; acc = a * b;
    a = cb; b = q[0]; acc = acc + a * b;
    a = cc; b = q[1]; acc = acc + a * b;
    neg = acc < 0;
    umag = neg ? -acc : acc;
    // zero spacing behaves as one LSB
    dvs = 128'((sp == 0) ? 1 : sp) << 17;
    quo = umag / dvs;
    if (quo > 128'(PART_CAP)) quo = 128'(PART_CAP);
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic void predict_cell(stencil_item_t it);
    longint part, total;
    logic sat;
    advection_res_t r;
    if (it.ax == 1'b0) begin
      part = axis_flux(it, dx_model);
      x_clip_model = (part > OUT_HI) || (part < OUT_LO);
      x_part_model = (part > OUT_HI) ? OUT_HI : (part < OUT_LO) ? OUT_LO : part;
    end else begin
      part = axis_flux(it, dz_model);
      total = x_part_model + part;
      sat = x_clip_model;
      if (total > OUT_HI) begin
        total = OUT_HI;
        sat = 1'b1;
      end else if (total < OUT_LO) begin
        total = OUT_LO;
        sat = 1'b1;
      end
      r.term = total[tvd_sb_pkg::OUT_WIDTH-1:0];
      r.sat = sat;
      term_queue.push_back(r);
      x_part_model = 0;
      x_clip_model = 1'b0;
    end
  endfunction

  // Monitor: every transfer is seen at the rising edge.
  always @(posedge clk) begin
    advection_res_t e;
    in_fired <= rst_n && in_valid && in_ready;
    cfg_fired <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tvd_sb_pkg::REG_GRID_SPACING_X) dx_model = cfg_data;
        else dz_model = cfg_data;
      end
      if (in_valid && in_ready) begin
        stencil_item_t it;
        it.ax = in_axis;
        it.v[0] = in_v_face_plus;  it.v[1] = in_v_face_minus;
        it.v[2] = in_v_face_plus_far; it.v[3] = in_v_face_minus_far;
        it.q[0] = in_q_center; it.q[1] = in_q_plus; it.q[2] = in_q_plus_far;
        it.q[3] = in_q_minus; it.q[4] = in_q_minus_far;
        predict_cell(it);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (term_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: term %0d sat %0b",
                     out_advection_term, out_saturated);
        end else begin
          e = term_queue.pop_front();
          if (e.term !== out_advection_term || e.sat !== out_saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: term exp %0d got %0d, sat exp %0b got %0b",
                       signed'(e.term), out_advection_term, e.sat, out_saturated);
          end
        end
      end
    end
  end

  // Driver: sends pending items in bursts separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk) begin
    stencil_item_t it;
    if (rst_n && !(in_valid && !in_fired)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_axis <= it.ax;
        in_v_face_plus <= it.v[0]; in_v_face_minus <= it.v[1];
        in_v_face_plus_far <= it.v[2]; in_v_face_minus_far <= it.v[3];
        in_q_center <= it.q[0]; in_q_plus <= it.q[1]; in_q_plus_far <= it.q[2];
        in_q_minus <= it.q[3]; in_q_minus_far <= it.q[4];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is re-picked at random from three modes; long hold on request.
  int rx_mode = 0;
  int rx_cnt = 0;
  always @(negedge clk) begin
    rx_cnt++;
    if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_rx) out_ready <= 1'b0;
    else case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Long receiver hold-off while the sender keeps offering items.
  initial begin
    wait (items_taken >= 400);
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 6)) - 3);
      2: return 32'h7fffffff;
      3: return 32'h80000000;
      4: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      5: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_item(logic ax, logic [31:0] v0, logic [31:0] v1,
                            logic [31:0] v2, logic [31:0] v3, logic [31:0] q0,
                            logic [31:0] q1, logic [31:0] q2, logic [31:0] q3,
                            logic [31:0] q4);
    stencil_item_t it;
    it.ax = ax;
    it.v[0] = v0; it.v[1] = v1; it.v[2] = v2; it.v[3] = v3;
    it.q[0] = q0; it.q[1] = q1; it.q[2] = q2; it.q[3] = q3; it.q[4] = q4;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(logic ax);
    queue_item(ax, pick_value(), pick_value(), pick_value(), pick_value(),
               pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  // Mostly well-formed cells, some repeated x items and lone z items.
  task automatic queue_cells(int n);
    int k;
    for (k = 0; k < n; ) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_random(1'b1);
          k += 1;
        end
        1: begin
          queue_random(1'b0); queue_random(1'b0); queue_random(1'b1);
          k += 3;
        end
        default: begin
          queue_random(1'b0); queue_random(1'b1);
          k += 2;
        end
      endcase
    end
  endtask

  task automatic write_spacing(tvd_sb_pkg::cfg_reg_t idx,
                               logic [tvd_sb_pkg::SPACING_WIDTH-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fired);
    cfg_valid <= 1'b0;
  endtask

  // Waits until everything sent has been answered, then lets a trailing
  // x item finish.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || term_queue.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset spacing
    queue_item(1'b1, 32'd65536, 32'd65536, 32'd65536, 32'd65536,
               32'd3, 32'd4, 32'd5, 32'd2, 32'd1);                 // lone z
    queue_item(1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0);          // all zero
    queue_item(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_item(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    queue_item(1'b1, 32'hffffffff, 32'h00000001, 32'hffffffff, 32'h00000001,
               32'hffffffff, 32'h0, 32'hffffffff, 32'h0, 32'hffffffff);
    // flat field: every ratio denominator zero
    queue_item(1'b0, 32'd65536, 32'd65536, 32'd65536, 32'd65536,
               32'd7, 32'd7, 32'd7, 32'd7, 32'd7);
    queue_item(1'b1, 32'hffff0000, 32'hffff0000, 32'hffff0000, 32'hffff0000,
               32'd7, 32'd7, 32'd7, 32'd7, 32'd7);
    // linear ramp: ratio one, then steep and reversing profiles
    queue_item(1'b0, 32'd65536, 32'd65536, 32'd65536, 32'd65536,
               32'd300, 32'd400, 32'd500, 32'd200, 32'd100);
    queue_item(1'b1, 32'hfff00000, 32'hfff00000, 32'hfff00000, 32'hfff00000,
               32'd300, 32'd400, 32'd500, 32'd200, 32'd100);
    queue_item(1'b0, 32'd40000, 32'd20000, 32'd90000, 32'd70000,
               32'd100, 32'd110, 32'd900, 32'd99, 32'd0);
    queue_item(1'b0, 32'd40000, 32'hffff8000, 32'd90000, 32'hfff00000,
               32'd100, 32'd50, 32'd500, 32'd120, 32'd10);          // repeated x
    queue_item(1'b1, 32'hffff0000, 32'd65536, 32'd0, 32'd0,
               32'd1000, 32'd990, 32'd1200, 32'd1003, 32'd990);
    // zero velocities with a nonzero stencil
    queue_item(1'b0, '0, '0, 32'd65536, 32'd65536,
               32'd10, 32'd20, 32'd40, 32'd5, 32'd1);
    queue_item(1'b1, 32'd5, 32'hfffffffb, 32'd0, 32'd3,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
    drain();

    // spacing of one LSB drives clipping of both the x part and the sum
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_X, 31'd1);
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_Z, 31'd1);
    queue_item(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_item(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_cells(200);
    drain();

    // zero spacing acts as one LSB
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_X, 31'd0);
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_Z, 31'd0);
    queue_cells(120);
    drain();

    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_X, 31'h7fffffff);
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_Z, 31'h7fffffff);
    queue_cells(180);
    drain();

    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_X, tvd_sb_pkg::SPACING_RESET);
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_Z, 31'd1);
    queue_cells(200);
    drain();

    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_X, 31'($urandom_range(1, 1 << 20)));
    write_spacing(tvd_sb_pkg::REG_GRID_SPACING_Z, 31'($urandom_range(1, 1 << 20)));
    queue_cells(300);
    drain();

    if (mismatches == 0 && term_queue.size() == 0) begin
      $display("PASS tvd_superbee_advection_stencil");
    end else begin
      $display("FAIL tvd_superbee_advection_stencil");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("FAIL tvd_superbee_advection_stencil");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tvd_sb_pkg.sv
rtl/tvd_sb_mul.sv
rtl/tvd_superbee_advection_stencil.sv
tb/sv/testbench.sv
